@@ design/drap_pkg.sv @@
// ----------------------------------------------------------------------------
// drap_pkg
// Shared types and codes for the DNS response answer parser.
// ----------------------------------------------------------------------------
package drap_pkg;

  localparam int KindWidth  = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [KindWidth-1:0] KindA     = 3'd0;
  localparam logic [KindWidth-1:0] KindCname = 3'd1;
  localparam logic [KindWidth-1:0] KindError = 3'd2;
  localparam logic [KindWidth-1:0] KindDone  = 3'd3;
  localparam logic [KindWidth-1:0] KindTrunc = 3'd4;

  localparam logic [15:0] TypeA     = 16'd1;
  localparam logic [15:0] TypeCname = 16'd5;
  localparam logic [7:0]  PtrMask   = 8'hc0;

  typedef struct packed {
    logic [KindWidth-1:0] result_kind;
    logic [31:0]          ipv4_address;
    logic [31:0]          time_to_live;
    logic [3:0]           response_code;
    logic                 end_of_message;
  } drap_result_t;

  // Results caused by one accepted byte: up to two, first slot filled first.
  typedef struct packed {
    logic [1:0]   count;
    drap_result_t first;
    drap_result_t second;
  } drap_push_t;

endpackage

@@ design/drap_byte_if.sv @@
// ----------------------------------------------------------------------------
// drap_byte_if
// Valid/ready channel carrying one message byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface drap_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ design/drap_result_if.sv @@
// ----------------------------------------------------------------------------
// drap_result_if
// Valid/ready channel carrying one parser result.
// ----------------------------------------------------------------------------
interface drap_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] ipv4_address;
  logic [31:0] time_to_live;
  logic [3:0]  response_code;
  logic        end_of_message;

  modport source (output valid, output result_kind, output ipv4_address,
                  output time_to_live, output response_code, output end_of_message,
                  input ready);
  modport sink   (input valid, input result_kind, input ipv4_address,
                  input time_to_live, input response_code, input end_of_message,
                  output ready);
endinterface

@@ design/drap_parser_core.sv @@
// ----------------------------------------------------------------------------
// drap_parser_core
// Byte-wide parse state machine: header, questions, answer records.
// ----------------------------------------------------------------------------
module drap_parser_core
  import drap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output drap_push_t push
);

  typedef enum logic [3:0] {
    PhHeader = 4'd0,
    PhQname  = 4'd1,
    PhQptr   = 4'd2,
    PhQfixed = 4'd3,
    PhAname  = 4'd4,
    PhAptr   = 4'd5,
    PhAfixed = 4'd6,
    PhRdata  = 4'd7,
    PhIgnore = 4'd8
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [15:0] field_byte_count, field_byte_count_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [5:0]  label_bytes_left, label_bytes_left_next;
  logic [15:0] record_type, record_type_next;
  logic [31:0] ttl_accumulator, ttl_accumulator_next;
  logic [15:0] rdata_length, rdata_length_next;
  logic [31:0] address_accumulator, address_accumulator_next;
  logic [3:0]  saved_rcode, saved_rcode_next;

  logic         rec_valid;
  drap_result_t rec;
  drap_result_t fin;
  logic         finish;
  logic         rdata_end;
  logic [15:0]  c;

  assign c         = field_byte_count;
  assign rdata_end = ({1'b0, c} + 17'd1) >= {1'b0, rdata_length};

  always_comb begin
    parse_phase_next         = parse_phase;
    field_byte_count_next    = field_byte_count;
    questions_left_next      = questions_left;
    answers_left_next        = answers_left;
    label_bytes_left_next    = label_bytes_left;
    record_type_next         = record_type;
    ttl_accumulator_next     = ttl_accumulator;
    rdata_length_next        = rdata_length;
    address_accumulator_next = address_accumulator;
    saved_rcode_next         = saved_rcode;
    rec_valid                = 1'b0;
    rec                      = '0;
    finish                   = 1'b0;

    unique case (parse_phase)
      PhHeader: begin
        if (c == 16'd3) begin
          saved_rcode_next = data_byte[3:0];
        end else if (c == 16'd4 || c == 16'd5) begin
          questions_left_next = {questions_left[7:0], data_byte};
        end else if (c == 16'd6 || c == 16'd7) begin
          answers_left_next = {answers_left[7:0], data_byte};
        end
        field_byte_count_next = c + 16'd1;
        if (c == 16'd3 && saved_rcode_next != 4'd0) begin
          rec_valid             = 1'b1;
          rec.result_kind       = KindError;
          rec.response_code     = saved_rcode_next;
          parse_phase_next      = PhIgnore;
        end else if (c >= 16'd11) begin
          label_bytes_left_next = '0;
          field_byte_count_next = '0;
          if (questions_left_next != 16'd0) begin
            parse_phase_next = PhQname;
          end else if (answers_left_next != 16'd0) begin
            parse_phase_next = PhAname;
          end else begin
            parse_phase_next = PhIgnore;
          end
        end
      end
      PhQname, PhAname: begin
        if (label_bytes_left != '0) begin
          label_bytes_left_next = label_bytes_left - 6'd1;
        end else if (data_byte == 8'd0) begin
          parse_phase_next      = (parse_phase == PhQname) ? PhQfixed : PhAfixed;
          field_byte_count_next = '0;
        end else if ((data_byte & PtrMask) == PtrMask) begin
          parse_phase_next = (parse_phase == PhQname) ? PhQptr : PhAptr;
        end else begin
          label_bytes_left_next = data_byte[5:0];
        end
      end
      PhQptr: begin
        parse_phase_next      = PhQfixed;
        field_byte_count_next = '0;
      end
      PhAptr: begin
        parse_phase_next      = PhAfixed;
        field_byte_count_next = '0;
      end
      PhQfixed: begin
        field_byte_count_next = c + 16'd1;
        if (c >= 16'd3) begin
          if (questions_left != 16'd0) begin
            questions_left_next = questions_left - 16'd1;
          end
          label_bytes_left_next = '0;
          field_byte_count_next = '0;
          if (questions_left_next != 16'd0) begin
            parse_phase_next = PhQname;
          end else if (answers_left != 16'd0) begin
            parse_phase_next = PhAname;
          end else begin
            parse_phase_next = PhIgnore;
          end
        end
      end
      PhAfixed: begin
        if (c == 16'd0) begin
          record_type_next         = {8'd0, data_byte};
          ttl_accumulator_next     = '0;
          rdata_length_next        = '0;
          address_accumulator_next = '0;
        end else if (c == 16'd1) begin
          record_type_next = {record_type[7:0], data_byte};
        end else if (c >= 16'd4 && c <= 16'd7) begin
          ttl_accumulator_next = {ttl_accumulator[23:0], data_byte};
        end else if (c == 16'd8 || c == 16'd9) begin
          rdata_length_next = {rdata_length[7:0], data_byte};
        end
        field_byte_count_next = c + 16'd1;
        if (c >= 16'd9) begin
          field_byte_count_next = '0;
          label_bytes_left_next = '0;
          if (rdata_length_next == 16'd0) begin
            finish = 1'b1;
          end else begin
            parse_phase_next = PhRdata;
          end
        end
      end
      PhRdata: begin
        if (c < 16'd4) begin
          address_accumulator_next = {address_accumulator[23:0], data_byte};
        end
        field_byte_count_next = c + 16'd1;
        if (rdata_end) begin
          finish = 1'b1;
        end
      end
      default: begin
        parse_phase_next = PhIgnore;
      end
    endcase

    // End of an answer record: emit by type, then move to the next answer if any.
    if (finish) begin
      if (record_type_next == TypeA) begin
        rec_valid        = 1'b1;
        rec.result_kind  = KindA;
        rec.ipv4_address = address_accumulator_next;
        rec.time_to_live = ttl_accumulator_next;
      end else if (record_type_next == TypeCname) begin
        rec_valid        = 1'b1;
        rec.result_kind  = KindCname;
        rec.time_to_live = ttl_accumulator_next;
      end
      if (answers_left != 16'd0) begin
        answers_left_next = answers_left - 16'd1;
      end
      field_byte_count_next = '0;
      parse_phase_next      = (answers_left_next != 16'd0) ? PhAname : PhIgnore;
    end

    fin                = '0;
    fin.result_kind    = (parse_phase_next == PhIgnore) ? KindDone : KindTrunc;
    fin.end_of_message = 1'b1;

    if (last_byte) begin
      parse_phase_next         = PhHeader;
      field_byte_count_next    = '0;
      questions_left_next      = '0;
      answers_left_next        = '0;
      label_bytes_left_next    = '0;
      record_type_next         = '0;
      ttl_accumulator_next     = '0;
      rdata_length_next        = '0;
      address_accumulator_next = '0;
      saved_rcode_next         = '0;
    end

    push.count  = {1'b0, rec_valid} + {1'b0, last_byte};
    push.first  = rec_valid ? rec : fin;
    push.second = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PhHeader;
      field_byte_count    <= '0;
      questions_left      <= '0;
      answers_left        <= '0;
      label_bytes_left    <= '0;
      record_type         <= '0;
      ttl_accumulator     <= '0;
      rdata_length        <= '0;
      address_accumulator <= '0;
      saved_rcode         <= '0;
    end else if (step) begin
      parse_phase         <= parse_phase_next;
      field_byte_count    <= field_byte_count_next;
      questions_left      <= questions_left_next;
      answers_left        <= answers_left_next;
      label_bytes_left    <= label_bytes_left_next;
      record_type         <= record_type_next;
      ttl_accumulator     <= ttl_accumulator_next;
      rdata_length        <= rdata_length_next;
      address_accumulator <= address_accumulator_next;
      saved_rcode         <= saved_rcode_next;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> parse_phase == PhHeader && field_byte_count == '0
                          && answers_left == '0)
    else $error("parser state not cleared after last byte");

  a_error_in_header: assert property (@(posedge clk) disable iff (rst)
    step && rec_valid && rec.result_kind == KindError |-> parse_phase == PhHeader)
    else $error("rcode error raised outside header");

  a_two_needs_last: assert property (@(posedge clk) disable iff (rst)
    step && push.count == 2'd2 |-> last_byte && rec_valid)
    else $error("two results without last byte");

endmodule

@@ design/drap_result_queue.sv @@
// ----------------------------------------------------------------------------
// drap_result_queue
// Small result FIFO taking up to two results per cycle, draining one.
// ----------------------------------------------------------------------------
module drap_result_queue
  import drap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_en,
  input  drap_push_t           push,
  output logic                 room,
  output logic                 head_valid,
  output drap_result_t         head,
  input  logic                 pop
);

  drap_result_t         entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueueCntW-1:0] count, count_next;
  logic [1:0]           push_n;
  logic [QueuePtrW-1:0] wr_ptr_plus1;

  assign push_n       = push_en ? push.count : 2'd0;
  assign wr_ptr_plus1 = wr_ptr + QueuePtrW'(1);
  assign room         = count <= QueueCntW'(QueueDepth - 2);
  assign head_valid   = count != '0;
  assign head         = entries[rd_ptr];
  assign count_next   = count + QueueCntW'(push_n) - QueueCntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> room)
    else $error("push without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty result queue");

endmodule

@@ design/dns_response_answer_parser.sv @@
// ----------------------------------------------------------------------------
// dns_response_answer_parser
// Parses a DNS response byte stream into A, CNAME, error and end results.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          role
//  message   in   data_byte[7:0], last_byte                        one byte/transaction
//  results   out  result_kind[2:0], ipv4_address[31:0],            one result/transaction
//                 time_to_live[31:0], response_code[3:0], end_of_message
//
//  One byte is taken per cycle while the FIFO has room; its results land in a
//  four-entry result FIFO the same edge and can be taken from the next cycle on.
//  A byte ending a record and the message yields two results; the FIFO drains
//  one per cycle while results.ready is high.
//  message.ready is high while the FIFO has room for two results.
//  Synchronous reset returns the parser to the header phase and empties the FIFO.
// ----------------------------------------------------------------------------
module dns_response_answer_parser
  import drap_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  drap_byte_if.sink     message,
  drap_result_if.source results
);

  drap_push_t   push;
  drap_result_t head;
  logic         room;
  logic         head_valid;
  logic         step;
  logic         pop;

  assign message.ready = room;
  assign step          = message.valid && room;
  assign pop           = head_valid && results.ready;

  drap_parser_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (message.data_byte),
    .last_byte (message.last_byte),
    .push      (push)
  );

  drap_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (step),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  assign results.valid          = head_valid;
  assign results.result_kind    = head.result_kind;
  assign results.ipv4_address   = head.ipv4_address;
  assign results.time_to_live   = head.time_to_live;
  assign results.response_code  = head.response_code;
  assign results.end_of_message = head.end_of_message;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives DNS response byte streams into the answer parser and checks every
// result against an in-bench parser model. Streams mix clean responses,
// error responses, cut-off messages and raw noise. Three idle mixes are run
// on the byte and result channels.
// ----------------------------------------------------------------------------
module tb_top;
  import drap_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int BytesPerMix  = 570;
  localparam int DrainCycles  = 20;

  typedef enum logic [3:0] {
    ScanHeader, QuestionName, QuestionPtr, QuestionTail,
    AnswerName, AnswerPtr, AnswerFixed, AnswerRdata, SkipRest
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic clk;
  logic rst;

  drap_byte_if   message_ch ();
  drap_result_if result_ch ();

  dns_response_answer_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .message (message_ch),
    .results (result_ch)
  );

  // byte stream waiting to be sent, results still owed by the parser
  msg_byte_t    tx_q[$];
  drap_result_t results_due[$];
  logic [7:0]   frame_bytes[$];

  int  send_idle_pct;
  int  take_idle_pct;
  bit  byte_held;
  int  cycle_count;
  int  mismatch_count;
  int  bytes_queued;
  int  frames_queued;
  int  results_seen;
  int  kind_seen[8];

  // parser model state
  scan_phase_e scan_phase;
  logic [15:0] fld_cnt;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [7:0]  label_left;
  logic [15:0] rr_type;
  logic [31:0] rr_ttl;
  logic [15:0] rr_rdlen;
  logic [31:0] rr_addr;
  logic [3:0]  hdr_rcode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  task automatic reset_parser();
    scan_phase = ScanHeader;
    fld_cnt    = '0;
    qd_left    = '0;
    an_left    = '0;
    label_left = '0;
    rr_type    = '0;
    rr_ttl     = '0;
    rr_rdlen   = '0;
    rr_addr    = '0;
    hdr_rcode  = '0;
  endtask

  task automatic due_result(input logic [2:0] kind, input logic [31:0] addr,
                            input logic [31:0] ttl, input logic [3:0] rc,
                            input logic eom);
    drap_result_t r;
    r.result_kind    = kind;
    r.ipv4_address   = addr;
    r.time_to_live   = ttl;
    r.response_code  = rc;
    r.end_of_message = eom;
    results_due.push_back(r);
  endtask

  task automatic begin_answers();
    fld_cnt = '0;
    if (an_left != 16'd0) scan_phase = AnswerName;
    else scan_phase = SkipRest;
  endtask

  task automatic begin_questions();
    fld_cnt = '0;
    if (qd_left != 16'd0) scan_phase = QuestionName;
    else begin_answers();
  endtask

  // one byte of an owner name; a pointer jumps to ptr_ph for its second byte
  task automatic walk_name_byte(input logic [7:0] b, input scan_phase_e ptr_ph,
                                output bit ended);
    ended = 1'b0;
    if (label_left != 8'd0) label_left = label_left - 8'd1;
    else if (b == 8'd0) ended = 1'b1;
    else if ((b & PtrMask) == PtrMask) scan_phase = ptr_ph;
    else label_left = b & 8'h3f;
  endtask

  task automatic close_record();
    if (rr_type == TypeA) due_result(KindA, rr_addr, rr_ttl, 4'd0, 1'b0);
    else if (rr_type == TypeCname) due_result(KindCname, 32'd0, rr_ttl, 4'd0, 1'b0);
    if (an_left != 16'd0) an_left = an_left - 16'd1;
    begin_answers();
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [15:0] c;
    bit          ended;
    c = fld_cnt;
    case (scan_phase)
      ScanHeader: begin
        if (c == 16'd3) hdr_rcode = b[3:0];
        else if (c == 16'd4 || c == 16'd5) qd_left = {qd_left[7:0], b};
        else if (c == 16'd6 || c == 16'd7) an_left = {an_left[7:0], b};
        fld_cnt = c + 16'd1;
        if (c == 16'd3 && hdr_rcode != 4'd0) begin
          due_result(KindError, 32'd0, 32'd0, hdr_rcode, 1'b0);
          scan_phase = SkipRest;
        end else if (c >= 16'd11) begin
          label_left = '0;
          begin_questions();
        end
      end
      QuestionName: begin
        walk_name_byte(b, QuestionPtr, ended);
        if (ended) begin
          scan_phase = QuestionTail;
          fld_cnt = '0;
        end
      end
      QuestionPtr: begin
        scan_phase = QuestionTail;
        fld_cnt = '0;
      end
      QuestionTail: begin
        fld_cnt = c + 16'd1;
        if (c >= 16'd3) begin
          if (qd_left != 16'd0) qd_left = qd_left - 16'd1;
          label_left = '0;
          begin_questions();
        end
      end
      AnswerName: begin
        walk_name_byte(b, AnswerPtr, ended);
        if (ended) begin
          scan_phase = AnswerFixed;
          fld_cnt = '0;
        end
      end
      AnswerPtr: begin
        scan_phase = AnswerFixed;
        fld_cnt = '0;
      end
      AnswerFixed: begin
        if (c == 16'd0) begin
          rr_type  = {8'h00, b};
          rr_ttl   = '0;
          rr_rdlen = '0;
          rr_addr  = '0;
        end else if (c == 16'd1) begin
          rr_type = {rr_type[7:0], b};
        end else if (c >= 16'd4 && c <= 16'd7) begin
          rr_ttl = {rr_ttl[23:0], b};
        end else if (c == 16'd8 || c == 16'd9) begin
          rr_rdlen = {rr_rdlen[7:0], b};
        end
        fld_cnt = c + 16'd1;
        if (c >= 16'd9) begin
          fld_cnt = '0;
          label_left = '0;
          if (rr_rdlen == 16'd0) close_record();
          else scan_phase = AnswerRdata;
        end
      end
      AnswerRdata: begin
        // address keeps the first four rdata bytes, right-aligned
        if (c < 16'd4) rr_addr = {rr_addr[23:0], b};
        fld_cnt = c + 16'd1;
        if (({1'b0, c} + 17'd1) >= {1'b0, rr_rdlen}) close_record();
      end
      default: scan_phase = SkipRest;
    endcase
    if (last) begin
      if (scan_phase == SkipRest) due_result(KindDone, 32'd0, 32'd0, 4'd0, 1'b1);
      else due_result(KindTrunc, 32'd0, 32'd0, 4'd0, 1'b1);
      reset_parser();
    end
  endtask

  // ---------------------------------------------------------------- frames

  task automatic put_header(input logic [3:0] rc, input logic [15:0] qd,
                            input logic [15:0] an);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back({4'($urandom), rc});
    frame_bytes.push_back(qd[15:8]);
    frame_bytes.push_back(qd[7:0]);
    frame_bytes.push_back(an[15:8]);
    frame_bytes.push_back(an[7:0]);
    repeat (4) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic put_name(input int labels, input bit ptr);
    int         len;
    logic [7:0] prefix;
    for (int i = 0; i < labels; i++) begin
      // reserved 01/10 prefixes still count as plain labels
      case ($urandom_range(0, 9))
        0:       prefix = 8'h40;
        1:       prefix = 8'h80;
        default: prefix = 8'h00;
      endcase
      len = (prefix != 8'h00) ? $urandom_range(0, 6) : $urandom_range(1, 6);
      if ($urandom_range(0, 29) == 0) len = 63;
      frame_bytes.push_back(prefix | 8'(len));
      repeat (len) frame_bytes.push_back(8'($urandom));
    end
    if (ptr) begin
      frame_bytes.push_back(PtrMask | 8'($urandom_range(0, 63)));
      frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(8'h00);
    end
  endtask

  task automatic put_question(input int labels, input bit ptr);
    put_name(labels, ptr);
    repeat (4) frame_bytes.push_back(8'($urandom));
  endtask

  // fill < 0 gives random rdata
  task automatic put_answer(input logic [15:0] rtype, input logic [31:0] ttl,
                            input int rdlen, input int fill);
    put_name($urandom_range(0, 2), $urandom_range(0, 1));
    frame_bytes.push_back(rtype[15:8]);
    frame_bytes.push_back(rtype[7:0]);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(ttl[31:24]);
    frame_bytes.push_back(ttl[23:16]);
    frame_bytes.push_back(ttl[15:8]);
    frame_bytes.push_back(ttl[7:0]);
    frame_bytes.push_back(rdlen[15:8]);
    frame_bytes.push_back(rdlen[7:0]);
    repeat (rdlen) frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  // keep <= 0 sends the whole frame, otherwise only its first keep bytes
  task automatic queue_frame(input int keep);
    msg_byte_t mb;
    if (keep <= 0 || keep > frame_bytes.size()) keep = frame_bytes.size();
    for (int i = 0; i < keep; i++) begin
      mb.data = frame_bytes[i];
      mb.last = (i == keep - 1);
      tx_q.push_back(mb);
    end
    bytes_queued += keep;
    frames_queued++;
    frame_bytes.delete();
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : byte_driver
    if (rst) begin
      message_ch.valid <= 1'b0;
    end else if (!byte_held) begin
      if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        message_ch.valid     <= 1'b1;
        message_ch.data_byte <= tx_q[0].data;
        message_ch.last_byte <= tx_q[0].last;
        byte_held = 1'b1;
      end else begin
        message_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : byte_accept
    if (!rst && message_ch.valid && message_ch.ready) begin
      parse_byte(message_ch.data_byte, message_ch.last_byte);
      void'(tx_q.pop_front());
      byte_held = 1'b0;
    end
  end

  always @(negedge clk) begin : result_stall
    result_ch.ready <= !rst && ($urandom_range(99) >= take_idle_pct);
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    drap_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      kind_seen[result_ch.result_kind]++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual kind %0d",
                 $time, result_ch.result_kind);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_ch.result_kind));
        check_field("ipv4_address", want.ipv4_address, result_ch.ipv4_address);
        check_field("time_to_live", want.time_to_live, result_ch.time_to_live);
        check_field("response_code", 32'(want.response_code),
                    32'(result_ch.response_code));
        check_field("end_of_message", 32'(want.end_of_message),
                    32'(result_ch.end_of_message));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d bytes unsent, %0d results outstanding",
               $time, tx_q.size(), results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int          send_idle_tbl[3];
    int          take_idle_tbl[3];
    int          mode;
    int          qd;
    int          an;
    int          rdlen;
    logic [15:0] rtype;
    logic [3:0]  rc;
    send_idle_tbl = '{36, 78, 0};
    take_idle_tbl = '{78, 36, 0};
    message_ch.valid     = 1'b0;
    message_ch.data_byte = 8'h00;
    message_ch.last_byte = 1'b0;
    result_ch.ready      = 1'b0;
    byte_held      = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    bytes_queued   = 0;
    frames_queued  = 0;
    results_seen   = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    send_idle_pct  = send_idle_tbl[0];
    take_idle_pct  = take_idle_tbl[0];
    reset_parser();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_idle_tbl[p];
      take_idle_pct = take_idle_tbl[p];
      if (p == 0) begin
        // empty response ending on the last header byte
        put_header(4'd0, 16'd0, 16'd0);
        queue_frame(0);
        // error code with the message cut right at the rcode byte
        put_header(4'hf, 16'd0, 16'd0);
        queue_frame(4);
        // error code, rest of message ignored
        put_header(4'h1, 16'd1, 16'd1);
        repeat (3) frame_bytes.push_back(8'($urandom));
        queue_frame(0);
        // lone byte is a truncated header
        frame_bytes.push_back(8'hff);
        queue_frame(0);
        // A extremes, empty CNAME, short and long rdata; last byte ends a record
        put_header(4'd0, 16'd1, 16'd5);
        put_question(2, 1'b0);
        put_answer(TypeA, 32'hffff_ffff, 4, 8'hff);
        put_answer(TypeA, 32'h0000_0000, 4, 8'h00);
        put_answer(TypeCname, $urandom, 0, -1);
        put_answer(TypeA, $urandom, 2, -1);
        put_answer(TypeA, $urandom, 6, -1);
        queue_frame(0);
        // all-ones counts, cut inside the header
        put_header(4'd0, 16'hffff, 16'hffff);
        queue_frame(9);
        // other type and A with no rdata, cut mid-record
        put_header(4'd0, 16'd0, 16'd3);
        put_answer(16'h0101, $urandom, 2, -1);
        put_answer(TypeA, $urandom, 0, -1);
        put_answer(TypeA, $urandom, 4, -1);
        queue_frame(frame_bytes.size() - 3);
      end

      while (bytes_queued < (p + 1) * BytesPerMix) begin
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
          repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
          queue_frame(0);
        end else begin
          rc = (mode < 16) ? 4'($urandom_range(1, 15)) : 4'd0;
          qd = $urandom_range(0, 2);
          an = $urandom_range(0, 3);
          put_header(rc, 16'(qd), 16'(an));
          repeat (qd) put_question($urandom_range(0, 3), $urandom_range(0, 3) == 0);
          repeat (an) begin
            case ($urandom_range(0, 3))
              0, 1: begin
                rtype = TypeA;
                rdlen = ($urandom_range(0, 9) != 0) ? 4 : $urandom_range(0, 8);
              end
              2: begin
                rtype = TypeCname;
                rdlen = $urandom_range(0, 12);
              end
              default: begin
                rtype = 16'($urandom);
                rdlen = $urandom_range(0, 10);
              end
            endcase
            if ($urandom_range(0, 49) == 0) rdlen = $urandom_range(16, 300);
            put_answer(rtype, $urandom, rdlen, -1);
          end
          if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
          queue_frame((mode < 26) ? $urandom_range(1, frame_bytes.size()) : 0);
        end
      end

      while (tx_q.size() != 0) @(posedge clk);
    end

    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d messages (%0d bytes) under three idle mixes; %0d results checked.",
             frames_queued, bytes_queued, results_seen);
    $display("Result kinds seen: A %0d, CNAME %0d, error %0d, done %0d, truncated %0d.",
             kind_seen[KindA], kind_seen[KindCname], kind_seen[KindError],
             kind_seen[KindDone], kind_seen[KindTrunc]);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
